// ----- rtl/core/srr_pkg.sv -----
// Shared types and constants of the stereo rational resampler.
// Used by srr_front, srr_back and the top level; no dependencies of its own.
`default_nettype none

package srr_pkg;

    // defaults for the top-level parameters
    localparam int MAX_TAPS_DEF       = 512;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // results kept per sample item
    localparam int RESULT_LIMIT = 64;

    localparam int SAT_HIGH = 32767;
    localparam int SAT_LOW  = -32768;

    // register file
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] UP_RESET   = 10'd80;
    localparam logic [CFG_W-1:0] DOWN_RESET = 10'd441;
    localparam logic [CFG_W-1:0] TAPS_RESET = 10'd441;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP   = 2'd0,
        CFG_DOWN = 2'd1,
        CFG_TAPS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] up;
        logic [CFG_W-1:0] down;
        logic [CFG_W-1:0] taps;
    } t_cfg;

    // input item layout
    localparam int COEF_IDX_W = 9;
    localparam int COEF_W     = 32;
    localparam int SAMPLE_W   = 16;

    localparam int IN_DATA_W  = 80;
    localparam int COEF_IDX_LSB = 0;
    localparam int COEF_LSB     = COEF_IDX_LSB + COEF_IDX_W;
    localparam int LEFT_LSB     = COEF_LSB + COEF_W;
    localparam int RIGHT_LSB    = LEFT_LSB + SAMPLE_W;

    localparam int OUT_DATA_W = 2 * SAMPLE_W;

    typedef enum logic [0:0] {
        ACT_COEF   = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef struct packed {
        t_action                      action;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0]     coef_value;
        logic signed [SAMPLE_W-1:0]   left_in;
        logic signed [SAMPLE_W-1:0]   right_in;
    } t_item;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ----- rtl/core/srr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module srr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/srr_front.sv -----
// Input side: unpacks stream items and holds them in a short queue.
// Depends on srr_pkg.
`default_nettype none

module srr_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // coef_index, coef_value, left_in, right_in, zero pad
    input  wire logic [srr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // action
    input  wire logic                           i_s_tuser,
    output logic                                o_q_valid,
    output srr_pkg::t_item                      o_q_item,
    input  wire logic                           i_q_pop
);

    localparam int QAW = (srr_pkg::QUEUE_DEPTH > 1) ? $clog2(srr_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(srr_pkg::QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] QLAST = QAW'(srr_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] QFULL = QCW'(srr_pkg::QUEUE_DEPTH);

    srr_pkg::t_item r_mem [srr_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;

    srr_pkg::t_item in_item;
    logic           push;
    logic           pop;

    always_comb begin
        in_item.action     = srr_pkg::t_action'(i_s_tuser);
        in_item.coef_index = i_s_tdata[srr_pkg::COEF_IDX_LSB +: srr_pkg::COEF_IDX_W];
        in_item.coef_value = i_s_tdata[srr_pkg::COEF_LSB +: srr_pkg::COEF_W];
        in_item.left_in    = i_s_tdata[srr_pkg::LEFT_LSB +: srr_pkg::SAMPLE_W];
        in_item.right_in   = i_s_tdata[srr_pkg::RIGHT_LSB +: srr_pkg::SAMPLE_W];
    end

    assign o_s_tready = (r_cnt != QFULL);
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rp];

    assign push = i_s_tvalid && o_s_tready;
    assign pop  = i_q_pop && o_q_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QLAST) ? '0 : r_wp + QAW'(1);
        end
        if (pop) begin
            n_rp = (r_rp == QLAST) ? '0 : r_rp + QAW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/srr_back.sv -----
// Back end: coefficient writes, slot sequencer, shared stereo MAC and result output.
// Depends on srr_pkg and srr_ram.
`default_nettype none

module srr_back #(
    parameter int MAX_TAPS       = srr_pkg::MAX_TAPS_DEF,
    parameter int COEF_FRAC_BITS = srr_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire srr_pkg::t_item                  i_q_item,
    output logic                                 o_q_pop,
    input  wire srr_pkg::t_cfg                   i_cfg,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [srr_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tlast
);

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int TW     = (CNT_W > srr_pkg::CFG_W) ? CNT_W : srr_pkg::CFG_W;
    localparam int SW     = srr_pkg::SAMPLE_W;
    localparam int CW     = srr_pkg::COEF_W;
    localparam int PROD_W = CW + SW;
    localparam int ACC_W  = PROD_W + AW;
    localparam int RC_W   = $clog2(srr_pkg::RESULT_LIMIT + 1);
    localparam int FW     = srr_pkg::CFG_W;

    localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(MAX_TAPS);
    localparam logic [TW-1:0]    TAPS_CAP  = TW'(MAX_TAPS);
    localparam logic [RC_W-1:0]  RES_CAP   = RC_W'(srr_pkg::RESULT_LIMIT);
    localparam logic signed [ACC_W-1:0] Q_HI = ACC_W'(srr_pkg::SAT_HIGH);
    localparam logic signed [ACC_W-1:0] Q_LO = ACC_W'(srr_pkg::SAT_LOW);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SLOT  = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_FLUSH = 7'b0001000,
        S_SCALE = 7'b0010000,
        S_PUSH  = 7'b0100000,
        S_END   = 7'b1000000
    } t_state;

    // truncate toward zero, then clamp to 16 bits
    function automatic logic [SW-1:0] sat16(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        logic                    rnd;
        q   = acc >>> COEF_FRAC_BITS;
        rnd = acc[ACC_W-1] && (acc[COEF_FRAC_BITS-1:0] != '0);
        q   = q + $signed({{(ACC_W-1){1'b0}}, rnd});
        if (q > Q_HI) begin
            q = Q_HI;
        end else if (q < Q_LO) begin
            q = Q_LO;
        end
        return q[SW-1:0];
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [FW-1:0]    r_phase, n_phase;
    logic [FW-1:0]    r_slot, n_slot;
    logic [RC_W-1:0]  r_count, n_count;
    logic [TW-1:0]    r_k, n_k;
    logic [TW-1:0]    r_taps, n_taps;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_p1_v, n_p1_v;
    logic             r_p1_hv, n_p1_hv;
    logic             r_p2_v, n_p2_v;
    logic             r_held_v, n_held_v;
    logic             r_out_v, n_out_v;
    logic             r_out_last, n_out_last;
    logic [2*SW-1:0]  r_out_data, n_out_data;
    logic [2*SW-1:0]  r_held, n_held;
    logic [2*SW-1:0]  r_new, n_new;
    logic [2*SW-1:0]  r_sample, n_sample;

    logic signed [PROD_W-1:0] r_pl, r_pr;
    logic signed [ACC_W-1:0]  r_accl, r_accr;
    logic                     acc_clr;

    // RAM ports
    logic             coef_we;
    logic [AW-1:0]    coef_waddr;
    logic [CW-1:0]    coef_rdata;
    logic             hist_we;
    logic [2*SW-1:0]  hist_wdata;
    logic [2*SW-1:0]  hist_rdata;
    logic             issue;

    logic [FW-1:0]    down_eff;
    logic [FW:0]      phase_inc;
    logic [FW-1:0]    phase_next;
    logic [TW-1:0]    taps_cfg, taps_eff;
    logic             emit;
    logic             last_slot;
    logic             can_push;
    logic             hv;

    logic signed [CW-1:0] c_op;
    logic signed [SW-1:0] hl_op, hr_op;

    assign down_eff   = (i_cfg.down == '0) ? FW'(1) : i_cfg.down;
    assign phase_inc  = {1'b0, r_phase} + (FW+1)'(1);
    assign phase_next = (phase_inc >= {1'b0, down_eff}) ? '0 : phase_inc[FW-1:0];
    assign taps_cfg   = TW'(i_cfg.taps);
    assign taps_eff   = (taps_cfg > TAPS_CAP) ? TAPS_CAP : taps_cfg;
    assign emit       = (r_phase == '0) && (r_count < RES_CAP);
    assign last_slot  = (r_slot == i_cfg.up - FW'(1));
    assign can_push   = !r_out_v || i_m_tready;
    assign issue      = (r_state == S_MAC) && (r_k < r_taps);
    assign hv         = (CNT_W'(r_idx) < r_fill);

    assign coef_waddr = AW'(i_q_item.coef_index);
    assign coef_we    = (r_state == S_IDLE) && i_q_valid
                        && (i_q_item.action == srr_pkg::ACT_COEF)
                        && (32'(i_q_item.coef_index) < MAX_TAPS);
    assign hist_we    = (r_state == S_SLOT);
    assign hist_wdata = (r_slot == '0) ? r_sample : '0;

    srr_ram #(.WIDTH(CW), .DEPTH(MAX_TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_q_item.coef_value),
        .i_re    (issue),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (coef_rdata)
    );

    // both channels share one history word: right in the upper half
    srr_ram #(.WIDTH(2*SW), .DEPTH(MAX_TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_ptr),
        .i_wdata (hist_wdata),
        .i_re    (issue),
        .i_raddr (r_idx),
        .o_rdata (hist_rdata)
    );

    // history entries not yet written since reset read as zero
    assign c_op  = coef_rdata;
    assign hl_op = r_p1_hv ? hist_rdata[SW-1:0]    : '0;
    assign hr_op = r_p1_hv ? hist_rdata[2*SW-1:SW] : '0;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_fill     = r_fill;
        n_phase    = r_phase;
        n_slot     = r_slot;
        n_count    = r_count;
        n_k        = r_k;
        n_taps     = r_taps;
        n_idx      = r_idx;
        n_held_v   = r_held_v;
        n_held     = r_held;
        n_new      = r_new;
        n_sample   = r_sample;
        n_out_v    = r_out_v;
        n_out_last = r_out_last;
        n_out_data = r_out_data;
        n_p1_v     = issue;
        n_p1_hv    = hv;
        n_p2_v     = r_p1_v;
        o_q_pop    = 1'b0;
        acc_clr    = 1'b0;

        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.action == srr_pkg::ACT_SAMPLE) begin
                        n_sample = {i_q_item.right_in, i_q_item.left_in};
                        n_slot   = '0;
                        n_count  = '0;
                        if (i_cfg.up != '0) begin
                            n_state = S_SLOT;
                        end
                    end
                end
            end
            S_SLOT: begin
                n_ptr   = (r_ptr == LAST_ADDR) ? '0 : r_ptr + AW'(1);
                if (r_fill != FILL_FULL) begin
                    n_fill = r_fill + CNT_W'(1);
                end
                n_phase = phase_next;
                if (emit) begin
                    // newest tap is the slot just written
                    n_count = r_count + RC_W'(1);
                    n_idx   = r_ptr;
                    n_k     = '0;
                    n_taps  = taps_eff;
                    acc_clr = 1'b1;
                    n_state = S_MAC;
                end else if (last_slot) begin
                    n_state = S_END;
                end else begin
                    n_slot = r_slot + FW'(1);
                end
            end
            S_MAC: begin
                if (issue) begin
                    n_k   = r_k + TW'(1);
                    n_idx = (r_idx == '0) ? LAST_ADDR : r_idx - AW'(1);
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_new   = {sat16(r_accr), sat16(r_accl)};
                n_state = S_PUSH;
            end
            S_PUSH: begin
                // a result is held back until it is known whether it is the last
                if (!r_held_v || can_push) begin
                    if (r_held_v) begin
                        n_out_v    = 1'b1;
                        n_out_data = r_held;
                        n_out_last = 1'b0;
                    end
                    n_held   = r_new;
                    n_held_v = 1'b1;
                    if (last_slot) begin
                        n_state = S_END;
                    end else begin
                        n_slot  = r_slot + FW'(1);
                        n_state = S_SLOT;
                    end
                end
            end
            S_END: begin
                if (!r_held_v) begin
                    n_state = S_IDLE;
                end else if (can_push) begin
                    n_out_v    = 1'b1;
                    n_out_data = r_held;
                    n_out_last = 1'b1;
                    n_held_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_phase  <= '0;
            r_slot   <= '0;
            r_count  <= '0;
            r_k      <= '0;
            r_taps   <= '0;
            r_idx    <= '0;
            r_p1_v   <= 1'b0;
            r_p1_hv  <= 1'b0;
            r_p2_v   <= 1'b0;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_fill   <= n_fill;
            r_phase  <= n_phase;
            r_slot   <= n_slot;
            r_count  <= n_count;
            r_k      <= n_k;
            r_taps   <= n_taps;
            r_idx    <= n_idx;
            r_p1_v   <= n_p1_v;
            r_p1_hv  <= n_p1_hv;
            r_p2_v   <= n_p2_v;
            r_held_v <= n_held_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_new      <= n_new;
        r_sample   <= n_sample;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_pl       <= c_op * hl_op;
        r_pr       <= c_op * hr_op;
        if (acc_clr) begin
            r_accl <= '0;
            r_accr <= '0;
        end else if (r_p2_v) begin
            r_accl <= r_accl + ACC_W'(r_pl);
            r_accr <= r_accr + ACC_W'(r_pr);
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/core/stereo_rational_resampler_core.sv -----
// Stereo rational resampler: upsample by up_factor, FIR, keep every down_factor-th slot.
// Top level; depends on srr_pkg, srr_front, srr_back (and srr_ram through srr_back).
//
// Input stream (i_s_*): tuser = 0 writes coefficient coef_value at tap coef_index,
// tuser = 1 delivers one stereo sample. Output stream (o_m_*): filtered left/right,
// tlast on the final result caused by a sample item.
// Config channel (i_cfg_*): index 0 up_factor, 1 down_factor, 2 taps_in_use; always
// ready; write only while the block is idle.
// Items go through a two-entry queue, so the input keeps accepting while the back end
// is busy until the queue is full. A coefficient item is written when the back end
// takes it while idle. A sample item runs through up_factor upsampled slots and gives
// R results (at most 64) with T effective taps each: one coefficient and one history
// read per tap through the shared multiply-accumulate of each channel.
// A result appears on the output after the next result of the same sample is
// computed, or when the sample's last slot is done.
// Reset clears the history (by fill count, no clearing pass), pointer, phase and control
// registers; coefficients are undefined until written. When the receiver stalls the
// output register holds its item and the back end waits once one more result is held.
`default_nettype none

module stereo_rational_resampler_core #(
    parameter int MAX_TAPS       = srr_pkg::MAX_TAPS_DEF,
    parameter int COEF_FRAC_BITS = srr_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // coef_index[8:0], coef_value[40:9], left_in[56:41], right_in[72:57], zeros[79:73]
    input  wire logic [srr_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // action
    input  wire logic                             i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // left_out[15:0], right_out[31:16]
    output logic [srr_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    output logic                                  o_m_tlast,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [srr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [srr_pkg::CFG_W-1:0]        i_cfg_data
);

    srr_pkg::t_cfg  r_cfg, n_cfg;
    logic           q_valid;
    srr_pkg::t_item q_item;
    logic           q_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (srr_pkg::t_cfg_idx'(i_cfg_index))
                srr_pkg::CFG_UP:   n_cfg.up   = i_cfg_data;
                srr_pkg::CFG_DOWN: n_cfg.down = i_cfg_data;
                srr_pkg::CFG_TAPS: n_cfg.taps = i_cfg_data;
                default:           n_cfg      = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up   <= srr_pkg::UP_RESET;
            r_cfg.down <= srr_pkg::DOWN_RESET;
            r_cfg.taps <= srr_pkg::TAPS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    srr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    srr_back #(
        .MAX_TAPS       (MAX_TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .i_cfg      (r_cfg),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
